[src/eac_pkg.sv]
package eac_pkg;

    localparam int TEXELS      = 16;
    localparam int IDX_W       = 4;
    localparam int LEVEL_W     = 11;
    localparam int BYTE_W      = 8;
    localparam int BLOCK_W     = 64;
    localparam int SEL_W       = 3;
    localparam int SUM_W       = 13;
    localparam int MOD_W       = 5;
    localparam int MUL_W       = 7;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 11'd2047;
    localparam logic [IDX_W-1:0]   LAST_INDEX  = 4'd15;
    // floor(x/257) == (x*65281) >> 24 for any 16-bit x
    localparam logic [15:0]        BYTE_RECIP  = 16'd65281;
    localparam int                 BYTE_SHIFT  = 24;
    localparam int                 SEL_TOP     = 45;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
        logic             last;
    } texel_ctl_t;

    typedef logic signed [MOD_W-1:0] mod_t;

    function automatic mod_t mod_lookup(input logic [3:0] tab, input logic [2:0] sel);
        mod_t row [0:7];
        unique case (tab)
            4'd0:  row = '{-5'sd3, -5'sd6, -5'sd9,  -5'sd15, 5'sd2, 5'sd5, 5'sd8, 5'sd14};
            4'd1:  row = '{-5'sd3, -5'sd7, -5'sd10, -5'sd13, 5'sd2, 5'sd6, 5'sd9, 5'sd12};
            4'd2:  row = '{-5'sd2, -5'sd5, -5'sd8,  -5'sd13, 5'sd1, 5'sd4, 5'sd7, 5'sd12};
            4'd3:  row = '{-5'sd2, -5'sd4, -5'sd6,  -5'sd13, 5'sd1, 5'sd3, 5'sd5, 5'sd12};
            4'd4:  row = '{-5'sd3, -5'sd6, -5'sd8,  -5'sd12, 5'sd2, 5'sd5, 5'sd7, 5'sd11};
            4'd5:  row = '{-5'sd3, -5'sd7, -5'sd9,  -5'sd11, 5'sd2, 5'sd6, 5'sd8, 5'sd10};
            4'd6:  row = '{-5'sd4, -5'sd7, -5'sd8,  -5'sd11, 5'sd3, 5'sd6, 5'sd7, 5'sd10};
            4'd7:  row = '{-5'sd3, -5'sd5, -5'sd8,  -5'sd11, 5'sd2, 5'sd4, 5'sd7, 5'sd10};
            4'd8:  row = '{-5'sd2, -5'sd6, -5'sd8,  -5'sd10, 5'sd1, 5'sd5, 5'sd7, 5'sd9};
            4'd9:  row = '{-5'sd2, -5'sd5, -5'sd8,  -5'sd10, 5'sd1, 5'sd4, 5'sd7, 5'sd9};
            4'd10: row = '{-5'sd2, -5'sd4, -5'sd8,  -5'sd10, 5'sd1, 5'sd3, 5'sd7, 5'sd9};
            4'd11: row = '{-5'sd2, -5'sd5, -5'sd7,  -5'sd10, 5'sd1, 5'sd4, 5'sd6, 5'sd9};
            4'd12: row = '{-5'sd3, -5'sd4, -5'sd7,  -5'sd10, 5'sd2, 5'sd3, 5'sd6, 5'sd9};
            4'd13: row = '{-5'sd1, -5'sd2, -5'sd3,  -5'sd10, 5'sd0, 5'sd1, 5'sd2, 5'sd9};
            4'd14: row = '{-5'sd4, -5'sd6, -5'sd8,  -5'sd9,  5'sd3, 5'sd5, 5'sd7, 5'sd8};
            default: row = '{-5'sd3, -5'sd5, -5'sd7, -5'sd9, 5'sd2, 5'sd4, 5'sd6, 5'sd8};
        endcase
        return row[sel];
    endfunction

endpackage

[src/eac_lane.sv]
module eac_lane (
    input  logic                        clk,
    input  logic [eac_pkg::BLOCK_W-1:0] blk,
    input  logic [eac_pkg::IDX_W-1:0]   index,
    output logic [eac_pkg::LEVEL_W-1:0] level_reg
);
    import eac_pkg::*;

    logic [7:0]              base;
    logic [3:0]              mul_raw;
    logic [3:0]              tab;
    logic [MUL_W-1:0]        mul;
    logic [3:0]              pos;
    logic [SEL_W-1:0]        sel;
    logic [SEL_W-1:0]        sels [0:TEXELS-1];
    mod_t                    modv;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;
    logic [LEVEL_W-1:0]      level_next;

    assign base    = blk[63:56];
    assign mul_raw = blk[55:52];
    assign tab     = blk[51:48];
    assign mul     = (mul_raw == 4'd0) ? MUL_W'(1) : {mul_raw, 3'b000};

    // selectors are column-major; index is raster (row*4+col)
    assign pos = {index[1:0], index[3:2]};

    always_comb
    begin
        for (int p = 0; p < TEXELS; p++)
        begin
            sels[p] = blk[SEL_TOP - 3*p +: SEL_W];
        end
    end

    assign sel  = sels[pos];
    assign modv = mod_lookup(tab, sel);
    assign prod = SUM_W'(modv) * $signed({{(SUM_W-MUL_W){1'b0}}, mul});
    assign sum  = $signed({2'b00, base, 3'b100}) + prod;

    always_comb
    begin
        priority if (sum < 0)
            level_next = '0;
        else if (sum > $signed({2'b00, LEVEL_MAX}))
            level_next = LEVEL_MAX;
        else
            level_next = sum[LEVEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

endmodule

[src/eac_merge.sv]
module eac_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  eac_pkg::texel_ctl_t         ctl,
    input  logic                        dual,
    input  logic [eac_pkg::LEVEL_W-1:0] red_level,
    input  logic [eac_pkg::LEVEL_W-1:0] green_level,
    output logic                        valid_reg,
    output logic [eac_pkg::IDX_W-1:0]   index_reg,
    output logic                        last_reg,
    output logic [eac_pkg::LEVEL_W-1:0] red_value_reg,
    output logic [eac_pkg::LEVEL_W-1:0] green_value_reg,
    output logic [eac_pkg::BYTE_W-1:0]  red_byte_reg,
    output logic [eac_pkg::BYTE_W-1:0]  green_byte_reg
);
    import eac_pkg::*;

    logic [LEVEL_W-1:0] green_level_m;
    logic [15:0]        red16;
    logic [15:0]        green16;
    logic [31:0]        red_prod;
    logic [31:0]        green_prod;

    assign green_level_m = dual ? green_level : '0;

    // replicate 11 bits to 16, then divide by 257 via reciprocal
    assign red16      = {red_level, red_level[10:6]};
    assign green16    = {green_level_m, green_level_m[10:6]};
    assign red_prod   = {16'b0, red16} * {16'b0, BYTE_RECIP};
    assign green_prod = {16'b0, green16} * {16'b0, BYTE_RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        index_reg       <= ctl.index;
        last_reg        <= ctl.last;
        red_value_reg   <= red_level;
        green_value_reg <= green_level_m;
        red_byte_reg    <= red_prod[BYTE_SHIFT +: BYTE_W];
        green_byte_reg  <= green_prod[BYTE_SHIFT +: BYTE_W];
    end

endmodule

[src/eac_block_decoder_core.sv]
// EAC R11/RG11 block decoder. Pulse start with red_block (and green_block
// when dual_channel is set) while busy is low; the block then emits sixteen
// texels in raster order, one per cycle, each marked by valid for a single
// cycle with last_texel on the sixteenth. The receiver cannot stall: every
// valid beat must be taken. A block occupies the texel counter until its last
// texel is issued, so a new block can be accepted back to back; busy drops
// during the cycle the last texel is issued. The first texel passes the
// counter, lane and merge registers. Red and green are decoded by two
// parallel lanes. dual_channel is written through dual_channel_wr_en/wr_data
// and should only change while no block is in flight.
module eac_block_decoder_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        dual_channel_wr_en,
    input  logic                        dual_channel_wr_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [eac_pkg::BLOCK_W-1:0] red_block,
    input  logic [eac_pkg::BLOCK_W-1:0] green_block,
    output logic                        valid,
    output logic [eac_pkg::IDX_W-1:0]   texel_index,
    output logic [eac_pkg::LEVEL_W-1:0] red_value,
    output logic [eac_pkg::LEVEL_W-1:0] green_value,
    output logic [eac_pkg::BYTE_W-1:0]  red_byte,
    output logic [eac_pkg::BYTE_W-1:0]  green_byte,
    output logic                        last_texel
);
    import eac_pkg::*;

    logic               dual_reg;
    logic               active_reg;
    logic               active_next;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   cnt_next;
    logic [BLOCK_W-1:0] red_blk_reg;
    logic [BLOCK_W-1:0] green_blk_reg;
    logic               accept;
    texel_ctl_t         ctl_cur;
    texel_ctl_t         ctl_reg;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;

    assign busy   = active_reg && (cnt_reg != LAST_INDEX);
    assign accept = start && !busy;

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (accept)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg == LAST_INDEX)
                active_next = 1'b0;
            else
                cnt_next = cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dual_reg   <= 1'b0;
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            ctl_reg    <= '0;
        end
        else
        begin
            if (dual_channel_wr_en)
                dual_reg <= dual_channel_wr_data;
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            ctl_reg    <= ctl_cur;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_blk_reg   <= red_block;
            green_blk_reg <= green_block;
        end
    end

    assign ctl_cur.valid = active_reg;
    assign ctl_cur.index = cnt_reg;
    assign ctl_cur.last  = (cnt_reg == LAST_INDEX);

    eac_lane u_red_lane (
        .clk       (clk),
        .blk       (red_blk_reg),
        .index     (cnt_reg),
        .level_reg (red_level)
    );

    eac_lane u_green_lane (
        .clk       (clk),
        .blk       (green_blk_reg),
        .index     (cnt_reg),
        .level_reg (green_level)
    );

    eac_merge u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl_reg),
        .dual            (dual_reg),
        .red_level       (red_level),
        .green_level     (green_level),
        .valid_reg       (valid),
        .index_reg       (texel_index),
        .last_reg        (last_texel),
        .red_value_reg   (red_value),
        .green_value_reg (green_value),
        .red_byte_reg    (red_byte),
        .green_byte_reg  (green_byte)
    );

    a_first_texel: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 (valid && texel_index == '0))
        else $error("first texel not issued three cycles after start");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (last_texel == (texel_index == LAST_INDEX)))
        else $error("last_texel does not match texel index");

    a_single_green: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !dual_reg) |-> (green_value == '0 && green_byte == '0))
        else $error("green nonzero in single channel mode");

    a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && cnt_reg == '0))
        else $error("block not held busy after start");

endmodule
